/* sv/hgrp_pkg.sv */
package hgrp_pkg;
  localparam int unsigned HeaderLimit = 8192;
  localparam int unsigned UrlLimit = 1024;
  localparam int unsigned BcW = $clog2(HeaderLimit + 1);
  localparam int unsigned UcW = $clog2(UrlLimit + 1);

  localparam logic [3:0] PH_METHOD  = 4'd0;
  localparam logic [3:0] PH_URL_GAP = 4'd1;
  localparam logic [3:0] PH_URL     = 4'd2;
  localparam logic [3:0] PH_VER_GAP = 4'd3;
  localparam logic [3:0] PH_VER     = 4'd4;
  localparam logic [3:0] PH_NAME    = 4'd5;
  localparam logic [3:0] PH_VAL_GAP = 4'd6;
  localparam logic [3:0] PH_VAL     = 4'd7;
  localparam logic [3:0] PH_REST    = 4'd8;
  localparam logic [3:0] PH_DISCARD = 4'd9;

  localparam logic [1:0] VERDICT_OK  = 2'd0;
  localparam logic [1:0] VERDICT_BAD = 2'd1;
  localparam logic [1:0] VERDICT_BIG = 2'd2;

  typedef struct packed {
    logic           url_valid;
    logic [7:0]     url_byte;
    logic           done_res;
    logic [1:0]     verdict;
    logic           persist_conn;
    logic [9:0]     url_length;
  } res_t;

  function automatic logic [7:0] kw_get(input logic [3:0] p);
    case (p)
      4'd0: kw_get = "G";
      4'd1: kw_get = "E";
      default: kw_get = "T";
    endcase
  endfunction

  function automatic logic [7:0] kw_ver(input logic [3:0] p);
    case (p)
      4'd0: kw_ver = "H";
      4'd1: kw_ver = "T";
      4'd2: kw_ver = "T";
      4'd3: kw_ver = "P";
      4'd4: kw_ver = "/";
      4'd5: kw_ver = "1";
      default: kw_ver = ".";
    endcase
  endfunction

  function automatic logic [7:0] kw_host(input logic [3:0] p);
    case (p)
      4'd0: kw_host = "h";
      4'd1: kw_host = "o";
      4'd2: kw_host = "s";
      default: kw_host = "t";
    endcase
  endfunction

  function automatic logic [7:0] kw_conn(input logic [3:0] p);
    case (p)
      4'd0: kw_conn = "c";
      4'd1: kw_conn = "o";
      4'd2: kw_conn = "n";
      4'd3: kw_conn = "n";
      4'd4: kw_conn = "e";
      4'd5: kw_conn = "c";
      4'd6: kw_conn = "t";
      4'd7: kw_conn = "i";
      4'd8: kw_conn = "o";
      default: kw_conn = "n";
    endcase
  endfunction

  function automatic logic [7:0] kw_keep(input logic [3:0] p);
    case (p)
      4'd0: kw_keep = "k";
      4'd1: kw_keep = "e";
      4'd2: kw_keep = "e";
      4'd3: kw_keep = "p";
      4'd4: kw_keep = "-";
      4'd5: kw_keep = "a";
      4'd6: kw_keep = "l";
      4'd7: kw_keep = "i";
      4'd8: kw_keep = "v";
      default: kw_keep = "e";
    endcase
  endfunction

  function automatic logic [7:0] kw_close(input logic [3:0] p);
    case (p)
      4'd0: kw_close = "c";
      4'd1: kw_close = "l";
      4'd2: kw_close = "o";
      4'd3: kw_close = "s";
      default: kw_close = "e";
    endcase
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction
endpackage

/* sv/hgrp_core.sv */
module hgrp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  output logic             emit_o,
  output hgrp_pkg::res_t   res_o
);
  import hgrp_pkg::*;

  logic [3:0]     ph_q, ph_d;
  logic [3:0]     kp_q, kp_d;
  logic [BcW-1:0] bc_q, bc_d;
  logic [UcW-1:0] uc_q, uc_d;
  logic [1:0]     tp_q, tp_d;
  logic           pf_q, pf_d, hs_q, hs_d, er_q, er_d;
  logic [1:0]     hc_q, hc_d, vc_q, vc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_METHOD;
      kp_q <= '0;
      bc_q <= '0;
      uc_q <= '0;
      tp_q <= '0;
      pf_q <= 1'b0;
      hs_q <= 1'b0;
      er_q <= 1'b0;
      hc_q <= 2'd3;
      vc_q <= 2'd3;
    end else if (step_i) begin
      ph_q <= ph_d;
      kp_q <= kp_d;
      bc_q <= bc_d;
      uc_q <= uc_d;
      tp_q <= tp_d;
      pf_q <= pf_d;
      hs_q <= hs_d;
      er_q <= er_d;
      hc_q <= hc_d;
      vc_q <= vc_d;
    end
  end

  logic [7:0] b, lc;
  logic       blank, line_end, term, delim, uv, done, fin;
  logic [3:0] p, kinc;
  logic [1:0] c;
  logic [1:0] vd;

  always_comb begin
    b = data_byte_i;
    lc = to_lower(b);
    blank = (b == " ") || (b == 8'h09);
    line_end = (b == 8'h0a) && (tp_q == 2'd1 || tp_q == 2'd3);
    term = (b == 8'h0a) && (tp_q == 2'd3);
    delim = (b == 8'h0d) || (b == " ");
    ph_d = ph_q; kp_d = kp_q; uc_d = uc_q; pf_d = pf_q; hs_d = hs_q;
    er_d = er_q; hc_d = hc_q; vc_d = vc_q;
    uv = 1'b0; fin = 1'b0; c = 2'd0;
    p = kp_q;
    kinc = (kp_q < 4'd15) ? kp_q + 4'd1 : kp_q;
    if (b == 8'h0d) tp_d = (tp_q == 2'd2) ? 2'd3 : 2'd1;
    else if (b == 8'h0a) tp_d = (tp_q == 2'd1) ? 2'd2 : 2'd0;
    else tp_d = 2'd0;
    bc_d = bc_q + 1'b1;

    case (ph_q)
      PH_METHOD: begin
        if (p < 4'd3) begin
          if (b != kw_get(p)) begin er_d = 1'b1; ph_d = PH_DISCARD; end
          else kp_d = kinc;
        end else if (blank) ph_d = PH_URL_GAP;
        else begin er_d = 1'b1; ph_d = PH_DISCARD; end
      end
      PH_URL_GAP: begin
        if (!blank) begin
          if (b != "/") begin er_d = 1'b1; ph_d = PH_DISCARD; end
          else begin uv = 1'b1; uc_d = UcW'(1); ph_d = PH_URL; end
        end
      end
      PH_URL: begin
        if (blank) ph_d = PH_VER_GAP;
        else if (line_end || uc_q >= UcW'(UrlLimit - 1)) begin
          er_d = 1'b1; ph_d = PH_DISCARD;
        end else begin uv = 1'b1; uc_d = uc_q + 1'b1; end
      end
      PH_VER_GAP, PH_VER: begin
        if (ph_q == PH_VER_GAP && blank) begin
        end else begin
          if (ph_q == PH_VER_GAP) begin p = 4'd0; kp_d = '0; ph_d = PH_VER; end
          kinc = p + 4'd1;
          if (p < 4'd7) begin
            if (b != kw_ver(p)) begin er_d = 1'b1; ph_d = PH_DISCARD; end
            else kp_d = kinc;
          end else if (p == 4'd7) begin
            if (b == "1") begin pf_d = 1'b1; kp_d = kinc; end
            else if (b == "0") begin pf_d = 1'b0; kp_d = kinc; end
            else begin er_d = 1'b1; ph_d = PH_DISCARD; end
          end else if (p == 4'd8) begin
            if (b != 8'h0d) begin er_d = 1'b1; ph_d = PH_DISCARD; end
            else kp_d = kinc;
          end else begin
            if (b != 8'h0a) begin er_d = 1'b1; ph_d = PH_DISCARD; end
            else begin ph_d = PH_NAME; kp_d = '0; hc_d = 2'd3; end
          end
        end
      end
      PH_NAME, PH_VAL_GAP, PH_VAL, PH_REST: begin
        if (line_end) begin
          ph_d = PH_NAME; kp_d = '0; hc_d = 2'd3;
        end else if (ph_q == PH_NAME) begin
          c = hc_q;
          if (c[0]) begin
            if (p < 4'd4) begin
              if (lc != kw_host(p)) c[0] = 1'b0;
            end else if (b == ":") begin
              hs_d = 1'b1; ph_d = PH_REST; fin = 1'b1;
            end else c[0] = 1'b0;
          end
          if (!fin && c[1]) begin
            if (p < 4'd10) begin
              if (lc != kw_conn(p)) c[1] = 1'b0;
            end else if (b == ":") begin
              ph_d = PH_VAL_GAP; kp_d = '0; vc_d = 2'd3; fin = 1'b1;
            end else c[1] = 1'b0;
          end
          if (!fin) begin
            hc_d = c; kp_d = kinc;
            if (c == 2'd0) ph_d = PH_REST;
          end
        end else if (ph_q == PH_REST) begin
        end else if (ph_q == PH_VAL_GAP && blank) begin
        end else begin
          if (ph_q == PH_VAL_GAP) begin
            ph_d = PH_VAL; p = 4'd0; kinc = 4'd1;
          end
          c = vc_q;
          if (c[0]) begin
            if (p < 4'd10) begin
              if (lc != kw_keep(p)) c[0] = 1'b0;
            end else if (delim) begin
              pf_d = 1'b1; ph_d = PH_REST; fin = 1'b1;
            end else c[0] = 1'b0;
          end
          if (!fin && c[1]) begin
            if (p < 4'd5) begin
              if (lc != kw_close(p)) c[1] = 1'b0;
            end else if (delim) begin
              pf_d = 1'b0; ph_d = PH_REST; fin = 1'b1;
            end else c[1] = 1'b0;
          end
          if (!fin) begin
            vc_d = c; kp_d = kinc;
            if (c == 2'd0) ph_d = PH_REST;
          end
        end
      end
      default: ph_d = PH_DISCARD;
    endcase

    done = 1'b0; vd = VERDICT_OK;
    if (term) begin
      done = 1'b1;
      vd = (er_d || !hs_d) ? VERDICT_BAD : VERDICT_OK;
    end else if (bc_d >= BcW'(HeaderLimit)) begin
      done = 1'b1; vd = VERDICT_BIG;
    end
    emit_o = uv || done;
    res_o.url_valid = uv;
    res_o.url_byte = uv ? b : 8'd0;
    res_o.done_res = done;
    res_o.verdict = vd;
    res_o.persist_conn = done && vd == VERDICT_OK && pf_d;
    res_o.url_length = (done && vd == VERDICT_OK) ? uc_d[9:0] : 10'd0;
    if (done) begin
      ph_d = PH_METHOD; kp_d = '0; bc_d = '0; uc_d = '0; tp_d = '0; pf_d = 1'b0;
      hs_d = 1'b0; er_d = 1'b0; hc_d = 2'd3; vc_d = 2'd3;
    end
  end
endmodule

/* sv/http_get_request_parser.sv */
// channel | signals                         | direction
// in      | in_valid_i/in_ready_o, data_byte_i | sink
// out     | out_valid_o/out_ready_i, result fields | source
// one byte per cycle while in_ready_o is high, state updated in the accept cycle
// results land in a two-entry output register (main + skid)
// in_ready_o drops only when both entries hold results
// asynchronous active-low reset returns the parser to the method phase
module http_get_request_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       url_valid_o,
  output logic [7:0] url_byte_o,
  output logic       done_res_o,
  output logic [1:0] verdict_o,
  output logic       persist_conn_o,
  output logic [9:0] url_length_o
);
  import hgrp_pkg::*;

  logic step, emit;
  res_t res;
  res_t main_q, skid_q;
  logic mv_q, sv_q;

  assign in_ready_o = !sv_q;
  assign step = in_valid_i && in_ready_o;

  hgrp_core u_core (
    .clk_i(clk_i), .rst_ni(rst_ni), .step_i(step), .data_byte_i(data_byte_i),
    .emit_o(emit), .res_o(res)
  );

  logic push, pop;
  assign push = step && emit;
  assign pop = mv_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (!mv_q || pop) begin
        mv_q <= sv_q || push;
        sv_q <= 1'b0;
      end else if (push) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!mv_q || pop) main_q <= sv_q ? skid_q : res;
    if (push && !(!mv_q || pop)) skid_q <= res;
    else if (push && sv_q) skid_q <= res;
  end

  assign out_valid_o = mv_q;
  assign url_valid_o = main_q.url_valid;
  assign url_byte_o = main_q.url_byte;
  assign done_res_o = main_q.done_res;
  assign verdict_o = main_q.verdict;
  assign persist_conn_o = main_q.persist_conn;
  assign url_length_o = main_q.url_length;
endmodule

/* sim/http_get_request_parser_tb.sv */
`timescale 1ns / 1ps

module http_get_request_parser_tb;
  import hgrp_pkg::*;

  localparam int unsigned MaxCycles = 400000;

  typedef struct {
    logic       url_valid;
    logic [7:0] url_byte;
    logic       done_res;
    logic [1:0] verdict;
    logic       persist_conn;
    logic [9:0] url_length;
  } parse_res_t;

  // predictor state
  class parse_scoreboard;
    parse_res_t pending[$];
    int         errors;
    logic [3:0] phase;
    logic [3:0] kpos;
    int unsigned nbytes;
    int unsigned nurl;
    logic [1:0] term;
    logic       persist;
    logic       host;
    logic       err;
    logic [1:0] hcand;
    logic [1:0] vcand;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_METHOD;
      kpos = '0;
      nbytes = 0;
      nurl = 0;
      term = '0;
      persist = 1'b0;
      host = 1'b0;
      err = 1'b0;
      hcand = 2'b11;
      vcand = 2'b11;
    endfunction

    function logic [7:0] lower(logic [7:0] b);
      return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function bit blank(logic [7:0] b);
      return b == " " || b == 8'h09;
    endfunction

    function void bail();
      err = 1'b1;
      phase = PH_DISCARD;
    endfunction

    function void bump();
      if (kpos < 15) kpos++;
    endfunction

    function void name_char(logic [7:0] b);
      string      hs;
      string      cs;
      logic [7:0] lc;
      logic [1:0] c;
      hs = "host";
      cs = "connection";
      lc = lower(b);
      c = hcand;
      if (c[0]) begin
        if (kpos < 4) begin
          if (lc != hs[kpos]) c[0] = 1'b0;
        end else if (b == ":") begin
          host = 1'b1;
          phase = PH_REST;
          return;
        end else c[0] = 1'b0;
      end
      if (c[1]) begin
        if (kpos < 10) begin
          if (lc != cs[kpos]) c[1] = 1'b0;
        end else if (b == ":") begin
          phase = PH_VAL_GAP;
          kpos = '0;
          vcand = 2'b11;
          return;
        end else c[1] = 1'b0;
      end
      hcand = c;
      bump();
      if (c == 2'b00) phase = PH_REST;
    endfunction

    function void value_char(logic [7:0] b);
      string      ks;
      string      cl;
      logic [7:0] lc;
      logic [1:0] c;
      bit         dl;
      ks = "keep-alive";
      cl = "close";
      lc = lower(b);
      c = vcand;
      dl = (b == 8'h0d || b == " ");
      if (c[0]) begin
        if (kpos < 10) begin
          if (lc != ks[kpos]) c[0] = 1'b0;
        end else if (dl) begin
          persist = 1'b1;
          phase = PH_REST;
          return;
        end else c[0] = 1'b0;
      end
      if (c[1]) begin
        if (kpos < 5) begin
          if (lc != cl[kpos]) c[1] = 1'b0;
        end else if (dl) begin
          persist = 1'b0;
          phase = PH_REST;
          return;
        end else c[1] = 1'b0;
      end
      vcand = c;
      bump();
      if (c == 2'b00) phase = PH_REST;
    endfunction

    function void note_beat(logic [7:0] b);
      string      gs;
      string      vs;
      logic [1:0] prev;
      bit         lend;
      bit         fin;
      bit         uv;
      bit         dn;
      logic [1:0] vd;
      parse_res_t r;
      gs = "GET";
      vs = "HTTP/1.";
      prev = term;
      lend = (b == 8'h0a) && (prev == 2'd1 || prev == 2'd3);
      fin = (b == 8'h0a) && (prev == 2'd3);
      uv = 1'b0;
      dn = 1'b0;
      vd = VERDICT_OK;
      if (b == 8'h0d) term = (prev == 2'd2) ? 2'd3 : 2'd1;
      else if (b == 8'h0a) term = (prev == 2'd1) ? 2'd2 : 2'd0;
      else term = 2'd0;
      nbytes++;
      case (phase)
        PH_METHOD: begin
          if (kpos < 3) begin
            if (b != gs[kpos]) bail(); else bump();
          end else if (blank(b)) phase = PH_URL_GAP;
          else bail();
        end
        PH_URL_GAP: begin
          if (!blank(b)) begin
            if (b != "/") bail();
            else begin
              uv = 1'b1;
              nurl = 1;
              phase = PH_URL;
            end
          end
        end
        PH_URL: begin
          if (blank(b)) phase = PH_VER_GAP;
          else if (lend || nurl >= UrlLimit - 1) bail();
          else begin
            uv = 1'b1;
            nurl++;
          end
        end
        PH_VER_GAP, PH_VER: begin
          if (phase == PH_VER_GAP && blank(b)) begin
          end else begin
            if (phase == PH_VER_GAP) begin
              phase = PH_VER;
              kpos = '0;
            end
            if (kpos < 7) begin
              if (b != vs[kpos]) bail(); else bump();
            end else if (kpos == 7) begin
              if (b == "1") begin
                persist = 1'b1;
                bump();
              end else if (b == "0") begin
                persist = 1'b0;
                bump();
              end else bail();
            end else if (kpos == 8) begin
              if (b != 8'h0d) bail(); else bump();
            end else if (b != 8'h0a) bail();
            else begin
              phase = PH_NAME;
              kpos = '0;
              hcand = 2'b11;
            end
          end
        end
        PH_NAME, PH_VAL_GAP, PH_VAL, PH_REST: begin
          if (lend) begin
            phase = PH_NAME;
            kpos = '0;
            hcand = 2'b11;
          end else if (phase == PH_NAME) name_char(b);
          else if (phase == PH_VAL_GAP) begin
            if (!blank(b)) begin
              phase = PH_VAL;
              kpos = '0;
              value_char(b);
            end
          end else if (phase == PH_VAL) value_char(b);
        end
        default: phase = PH_DISCARD;
      endcase
      if (fin) begin
        dn = 1'b1;
        vd = (err || !host) ? VERDICT_BAD : VERDICT_OK;
      end else if (nbytes >= HeaderLimit) begin
        dn = 1'b1;
        vd = VERDICT_BIG;
      end
      if (!uv && !dn) return;
      r.url_valid = uv;
      r.url_byte = uv ? b : 8'd0;
      r.done_res = dn;
      r.verdict = vd;
      r.persist_conn = (dn && vd == VERDICT_OK) ? persist : 1'b0;
      r.url_length = (dn && vd == VERDICT_OK) ? nurl[9:0] : 10'd0;
      pending.push_back(r);
      if (dn) clear();
    endfunction

    function void check_beat(parse_res_t a);
      parse_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result beat");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.url_valid !== e.url_valid) begin
        $error("url_valid exp %0d got %0d", e.url_valid, a.url_valid);
        errors++;
      end
      if (a.url_byte !== e.url_byte) begin
        $error("url_byte exp %0h got %0h", e.url_byte, a.url_byte);
        errors++;
      end
      if (a.done_res !== e.done_res) begin
        $error("done_res exp %0d got %0d", e.done_res, a.done_res);
        errors++;
      end
      if (a.verdict !== e.verdict) begin
        $error("verdict exp %0d got %0d", e.verdict, a.verdict);
        errors++;
      end
      if (a.persist_conn !== e.persist_conn) begin
        $error("persist_conn exp %0d got %0d", e.persist_conn, a.persist_conn);
        errors++;
      end
      if (a.url_length !== e.url_length) begin
        $error("url_length exp %0d got %0d", e.url_length, a.url_length);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       in_valid_i = 0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 0;
  logic       out_valid_o;
  logic       out_ready_i = 0;
  logic       url_valid_o;
  logic [7:0] url_byte_o;
  logic       done_res_o;
  logic [1:0] verdict_o;
  logic       persist_conn_o;
  logic [9:0] url_length_o;

  parse_scoreboard sb;
  int unsigned     cycles = 0;
  bit              hold_off = 0;
  byte unsigned    stream[$];

  http_get_request_parser dut (.*);

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side
  always @(posedge clk_i) begin
    parse_res_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      r.url_valid = url_valid_o;
      r.url_byte = url_byte_o;
      r.done_res = done_res_o;
      r.verdict = verdict_o;
      r.persist_conn = persist_conn_o;
      r.url_length = url_length_o;
      sb.check_beat(r);
    end
    if (!rst_ni || hold_off) out_ready_i <= 0;
    else if (cycles % 64 < 20) out_ready_i <= 1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
  endtask

  task automatic add_request();
    string ver;
    string conn;
    int    k;
    int    n;
    k = $urandom_range(0, 9);
    add_str(k == 0 ? "GeT" : "GET");
    repeat ($urandom_range(1, 2)) add_str($urandom_range(0, 1) ? " " : "\t");
    add_str(k == 1 ? "x" : "/");
    n = $urandom_range(0, 12);
    repeat (n) stream.push_back(k == 2 ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(33, 126)));
    add_str(" ");
    ver = $urandom_range(0, 1) ? "HTTP/1.1\r\n" : "HTTP/1.0\r\n";
    if (k == 3) ver = "HTTP/1.2\r\n";
    add_str(ver);
    if ($urandom_range(0, 7) != 0) add_str($urandom_range(0, 1) ? "Host: a\r\n" : "hOST:b\r\n");
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 4))
        0: conn = "Connection: keep-alive\r\n";
        1: conn = "CONNECTION:\tClose\r\n";
        2: conn = "connection: keep-alivex\r\n";
        3: conn = "Connection: close xyz\r\n";
        default: conn = "Conn: close\r\n";
      endcase
      add_str(conn);
    end
    if (k == 4) stream.push_back(8'h00);
    add_str("\r\n");
  endtask

  task automatic send_all();
    int burst;
    while (stream.size() > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && stream.size() > 0) begin
        in_valid_i <= 1;
        data_byte_i <= stream[0];
        @(posedge clk_i);
        while (!in_ready_o) @(posedge clk_i);
        sb.note_beat(stream.pop_front());
        burst--;
      end
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    in_valid_i <= 0;
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed
    add_str("GET /a HTTP/1.1\r\nHost: x\r\n\r\n");
    add_str("GET\t /\xff HTTP/1.0\r\nhost:\r\nConnection: keep-alive\r\n\r\n");
    add_str("POST / HTTP/1.1\r\n\r\n");
    add_str("GET /a\rb\nc HTTP/1.1\r\nConnection: close\r\nHost:y\r\n\r\n");
    stream.push_back(8'h00);
    add_str("\r\n\r\n");
    send_all();
    // long url
    add_str("GET /");
    repeat (UrlLimit + 4) add_str("u");
    add_str(" HTTP/1.1\r\n\r\n");
    send_all();
    // size limit
    add_str("GET /");
    while (stream.size() < HeaderLimit + 10) add_str("v");
    while (stream.size() > HeaderLimit) void'(stream.pop_back());
    send_all();
    // receiver holds off while the sender keeps going
    fork
      begin
        hold_off = 1;
        repeat (200) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        add_str("GET /abcdefghij HTTP/1.1\r\nHost: z\r\n\r\n");
        send_all();
      end
    join
    // random
    while (stream.size() < 700) begin
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 20)) stream.push_back(8'($urandom));
      else add_request();
    end
    send_all();
    while (sb.pending.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
